@@ src/fp32_e4m3_converter_top_defines.svh @@
// Assertion macros used by the checker file fec_checker.sv
`ifndef FP32_E4M3_CONVERTER_TOP_DEFINES_SVH
`define FP32_E4M3_CONVERTER_TOP_DEFINES_SVH

`define FEC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define FEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/fec_pkg.sv @@
package fec_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned ModeWidth  = 1;

  typedef enum logic [ModeWidth-1:0] {
    MODE_TO_E4M3   = 1'b0,
    MODE_FROM_E4M3 = 1'b1
  } mode_e;

  localparam logic [7:0]  E4M3_POS_MAX = 8'h7E;
  localparam logic [7:0]  E4M3_NAN     = 8'h7F;
  localparam logic [31:0] F32_QNAN     = 32'h7FC0_0000;
  localparam logic [7:0]  F32_BIAS     = 8'd127;

  typedef struct packed {
    mode_e                  mode;
    logic [ValueWidth-1:0]  value_in;
  } in_word_t;

  typedef struct packed {
    logic [ValueWidth-1:0] value_out;
  } out_word_t;

endpackage

@@ src/fec_if.sv @@
interface fec_in_if;
  logic             valid;
  logic             ready;
  fec_pkg::in_word_t word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface fec_out_if;
  logic              valid;
  logic              ready;
  fec_pkg::out_word_t word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

@@ src/fec_to_e4m3.sv @@
module fec_to_e4m3 (
  input  logic [31:0] value_i,
  output logic [7:0]  byte_o
);
  logic        sign;
  logic [7:0]  ex;
  logic [23:0] sig;
  logic [4:0]  r;
  logic [4:0]  be;
  logic [4:0]  sh;
  logic [23:0] shifted;
  logic        rbit;
  logic [3:0]  q;

  always_comb begin
    sign    = value_i[31];
    ex      = value_i[30:23];
    sig     = {1'b1, value_i[22:0]};
    r       = {1'b0, sig[23:20]} + {4'd0, sig[19]};
    // biased E4M3 exponent: ex - 120, valid for ex in 121..135
    be      = 5'(ex - 8'd120) + {4'd0, r[4]};
    // quanta of 2^-9: shift 21..24 for ex in 120..117
    sh      = 5'(8'd141 - ex);
    shifted = sig >> sh;
    rbit    = sig[5'(sh - 5'd1)];
    q       = shifted[3:0] + {3'd0, rbit};
    byte_o  = {sign, 7'd0};
    if (ex == 8'hFF) begin
      byte_o = (value_i[22:0] != '0) ? fec_pkg::E4M3_NAN : {sign, fec_pkg::E4M3_POS_MAX[6:0]};
    end else if (ex == 8'd0) begin
      byte_o = {sign, 7'd0};
    end else if (ex > 8'd135) begin
      byte_o = {sign, fec_pkg::E4M3_POS_MAX[6:0]};
    end else if (ex >= 8'd121) begin
      if (be > 5'd15 || (be == 5'd15 && r[2:0] == 3'd7 && !r[4])) begin
        byte_o = {sign, fec_pkg::E4M3_POS_MAX[6:0]};
      end else begin
        byte_o = {sign, be[3:0], (r[4] ? 3'd0 : r[2:0])};
      end
    end else if (ex >= 8'd117) begin
      byte_o = {sign, 3'd0, q};
    end
  end
endmodule

@@ src/fec_from_e4m3.sv @@
module fec_from_e4m3 (
  input  logic [7:0]  byte_i,
  output logic [31:0] value_o
);
  logic       sign;
  logic [3:0] e4;
  logic [2:0] m;
  logic [1:0] p;
  logic [22:0] frac;

  always_comb begin
    sign = byte_i[7];
    e4   = byte_i[6:3];
    m    = byte_i[2:0];
    p    = m[2] ? 2'd2 : (m[1] ? 2'd1 : 2'd0);
    frac = 23'({20'd0, m} << (5'd23 - {3'd0, p}));
    if (byte_i[6:0] == 7'h7F) begin
      value_o = fec_pkg::F32_QNAN;
    end else if (e4 == 4'd0) begin
      if (m == 3'd0) begin
        value_o = {sign, 31'd0};
      end else begin
        value_o = {sign, 8'({6'd0, p} + 8'd118), frac};
      end
    end else begin
      value_o = {sign, 8'({4'd0, e4} + 8'd120), m, 20'd0};
    end
  end
endmodule

@@ src/fp32_e4m3_converter_top.sv @@
// Path: an accepted word enters the input register, then the output register, then out_if.
// Throughput: one word per cycle unless out_if.ready stalls; input and output register
// each hold one word and advance whenever the next stage is free.
// Reset: rst_ni asynchronous, active low; clears valid flags only.
module fp32_e4m3_converter_top (
  input logic    clk_i,
  input logic    rst_ni,
  fec_in_if.sink    in_if,
  fec_out_if.source out_if
);
  logic               in_vld_q;
  fec_pkg::in_word_t  in_q;
  logic               out_vld_q;
  logic [31:0]        out_q;
  logic               out_adv;
  logic               in_adv;
  logic [7:0]         e4m3;
  logic [31:0]        f32;
  logic [31:0]        res_d;

  assign out_adv = !out_vld_q || out_if.ready;
  assign in_adv  = !in_vld_q || out_adv;
  assign in_if.ready = in_adv;

  fec_to_e4m3 u_to (.value_i(in_q.value_in), .byte_o(e4m3));
  fec_from_e4m3 u_from (.byte_i(in_q.value_in[7:0]), .value_o(f32));

  assign res_d = (in_q.mode == fec_pkg::MODE_TO_E4M3) ? {24'd0, e4m3} : f32;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_adv) in_vld_q <= in_if.valid;
      if (out_adv) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_if.valid) in_q <= in_if.word;
    if (out_adv && in_vld_q) out_q <= res_d;
  end

  assign out_if.valid = out_vld_q;
  assign out_if.word.value_out = out_q;
endmodule

@@ src/fec_checker.sv @@
`include "fp32_e4m3_converter_top_defines.svh"

module fec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value
);
  `FEC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_value))
  `FEC_ASSERT_IMPL(a_ready_when_free, clk_i, rst_ni, !out_valid, in_ready)
  `FEC_ASSERT_NEXT(a_flow, clk_i, rst_ni, in_valid && in_ready && out_ready, ##1 out_valid)
endmodule

bind fp32_e4m3_converter_top fec_checker u_fec_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_valid (in_if.valid),
  .in_ready (in_if.ready),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .out_value(out_if.word.value_out)
);
